// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-check macros; empty outside simulation.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a implies b in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed: implication");

// a implies b, with b checked later than a
`define ASSERT_IMPLIES_2(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> ##2 (b)) \
    else $error("assertion failed: delayed implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_IMPLIES_2(label, clk, rst, a, b)

`endif

`endif

// ----- hdl/wea_pkg.sv -----
// ----------------------------------------------------------------------------
// Filter package
// Widths, reset values, register indexes and queue status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wea_pkg;

  localparam int SAMPLE_W      = 8;
  localparam int CFG_DATA_W    = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] WEIGHT_RESET = 8'd64;
  localparam logic [7:0] FULL_SCALE   = 8'd255;
  localparam logic [8:0] NORM_SPLIT   = 9'd128;
  localparam logic [8:0] NORM_MAX     = 9'd256;

  // register indexes on the configuration port
  localparam logic REG_WEIGHT     = 1'b0;
  localparam logic REG_COMPLEMENT = 1'b1;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ----- hdl/weighted_exponential_average_filter.sv -----
// ----------------------------------------------------------------------------
// Weighted exponential average filter
// Signed 8-bit sample smoother with an optional normalised high-pass output.
// ----------------------------------------------------------------------------
//  channel  | signals                           | transfer
//  ---------+-----------------------------------+-----------------------------
//  input    | push, full, sample_in             | push & !full
//  result   | empty, pop, sample_out            | pop & !empty
//  config   | cfg_we, cfg_index, cfg_data       | cfg_we
//
//  Each sample passes through the back-end steps weigh, mix and normalise; the
//  running average is a single register, so samples are processed in turn.
//  Input and result queues of QUEUE_DEPTH entries let either side stall alone.
//  Synchronous reset clears both queues and the average, weight to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module weighted_exponential_average_filter #(
  parameter int QUEUE_DEPTH = wea_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [wea_pkg::SAMPLE_W-1:0]   sample_in,
  output logic                           empty,
  input  logic                           pop,
  output logic [wea_pkg::SAMPLE_W-1:0]   sample_out,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wea_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wea_pkg::*;

  logic [7:0]          weight;
  logic                complement_mode;
  q_status_t           in_status;
  q_status_t           out_status;
  logic [SAMPLE_W-1:0] core_sample;
  logic [SAMPLE_W-1:0] core_result;
  logic                core_pop;
  logic                core_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight          <= WEIGHT_RESET;
      complement_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT:     weight          <= cfg_data[7:0];
        REG_COMPLEMENT: complement_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wea_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_in_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (sample_in),
    .rd_en   (core_pop),
    .rd_data (core_sample),
    .status  (in_status)
  );

  wea_core u_core (
    .clk             (clk),
    .rst             (rst),
    .weight          (weight),
    .complement_mode (complement_mode),
    .in_status       (in_status),
    .in_data         (core_sample),
    .in_pop          (core_pop),
    .out_status      (out_status),
    .out_push        (core_push),
    .out_data        (core_result)
  );

  wea_fifo #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SAMPLE_W)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (core_push),
    .wr_data (core_result),
    .rd_en   (pop),
    .rd_data (sample_out),
    .status  (out_status)
  );

  assign full  = in_status.full;
  assign empty = out_status.empty;

  `ASSERT_IMPLIES(a_pop_has_data, clk, rst, core_pop, !in_status.empty)
  `ASSERT_IMPLIES(a_push_has_room, clk, rst, core_push, !out_status.full)
  `ASSERT_IMPLIES_2(a_request_completes, clk, rst, core_pop, core_push)
  `ASSERT_IMPLIES(a_no_overlap, clk, rst, core_push, !core_pop)

endmodule

// ----- hdl/wea_fifo.sv -----
// ----------------------------------------------------------------------------
// Filter queue
// Small synchronous FIFO used at the filter's input and result ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wea_fifo #(
  parameter int DEPTH = wea_pkg::QUEUE_DEPTH,
  parameter int WIDTH = wea_pkg::SAMPLE_W
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [WIDTH-1:0]   wr_data,
  input  logic               rd_en,
  output logic [WIDTH-1:0]   rd_data,
  output wea_pkg::q_status_t status
);
  import wea_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign status.empty = (count == '0);
  assign status.full  = (count == CW'(DEPTH));
  assign do_wr        = wr_en && !status.full;
  assign do_rd        = rd_en && !status.empty;
  assign rd_data      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/wea_core.sv -----
// ----------------------------------------------------------------------------
// Filter core
// Three-step back end: weigh, mix into the running average, normalise.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wea_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [7:0]                    weight,
  input  logic                          complement_mode,
  input  wea_pkg::q_status_t            in_status,
  input  logic [wea_pkg::SAMPLE_W-1:0]  in_data,
  output logic                          in_pop,
  input  wea_pkg::q_status_t            out_status,
  output logic                          out_push,
  output logic [wea_pkg::SAMPLE_W-1:0]  out_data
);
  import wea_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MIX, ST_NORM} state_t;

  state_t             state;
  logic        [7:0]  average;
  logic        [7:0]  sample_q;
  logic        [15:0] prod_new_q;
  logic        [15:0] prod_old_q;
  logic signed [8:0]  diff_q;
  logic        [8:0]  norm_q;

  logic signed [16:0] prod_new;
  logic signed [16:0] prod_old;
  logic        [7:0]  inv_weight;
  logic        [7:0]  hi_new;
  logic        [7:0]  hi_old;
  logic        [7:0]  average_next;
  logic signed [8:0]  diff;
  logic        [8:0]  norm;
  logic signed [18:0] prod_diff;
  logic               start;

  // room in the result queue is checked at start; only one request in flight
  assign start    = (state == ST_IDLE) && !in_status.empty && !out_status.full;
  assign in_pop   = start;
  assign out_push = (state == ST_NORM);

  assign inv_weight = FULL_SCALE - weight;
  assign prod_new   = $signed(in_data) * $signed({1'b0, weight});
  assign prod_old   = $signed(average) * $signed({1'b0, inv_weight});

  // round the high byte up on bit 7 of the low byte, wrapping
  assign hi_new       = prod_new_q[15:8] + {7'b0, prod_new_q[7]};
  assign hi_old       = prod_old_q[15:8] + {7'b0, prod_old_q[7]};
  assign average_next = hi_new + hi_old;
  assign diff         = $signed({sample_q[7], sample_q})
                        - $signed({average_next[7], average_next});
  assign norm         = weight[7] ? NORM_MAX : ({1'b0, weight} + NORM_SPLIT);

  assign prod_diff = diff_q * $signed({1'b0, norm_q});
  assign out_data  = complement_mode ? prod_diff[15:8] : average;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      average <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          average <= average_next;
          state   <= ST_NORM;
        end
        ST_NORM: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sample_q   <= in_data;
      prod_new_q <= prod_new[15:0];
      prod_old_q <= prod_old[15:0];
    end
    if (state == ST_MIX) begin
      diff_q <= diff;
      norm_q <= norm;
    end
  end

endmodule
